// ===== rtl/sparse_chunked_tile_store_top_defines.svh =====
// Assertion macros shared by the sparse chunked tile store RTL.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef SPARSE_CHUNKED_TILE_STORE_TOP_DEFINES_SVH
`define SPARSE_CHUNKED_TILE_STORE_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SCT_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that one condition implies another in the same cycle.
`define SCT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ===== rtl/sct_pkg.sv =====
// Package of the sparse chunked tile store: payload types, FSM states, defaults.
// No dependencies.
package sct_pkg;

	localparam int TILE_SHIFT_DEF  = 4;
	localparam int HASH_SLOTS_DEF  = 64;
	localparam int POOL_CHUNKS_DEF = 64;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] tile_x;
		logic signed [31:0] tile_y;
		logic signed [31:0] tile_z;
		logic [31:0]        write_value;
	} in_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        chunk_found;
		logic        pool_full;
	} out_t;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_KREAD,
		S_KCMP,
		S_NEWKEY,
		S_LINK,
		S_FILL,
		S_STORE,
		S_TREAD,
		S_TDATA,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		SL_IDLE,
		SL_SUM,
		SL_MUL,
		SL_QUO,
		SL_REM,
		SL_DONE
	} slot_state_t;

	// Key memory port control
	typedef struct packed {
		logic re;
		logic we;
		logic set_valid;
	} kctl_t;

endpackage

// ===== rtl/sparse_chunked_tile_store_top.sv =====
// Top level of the sparse chunked tile store: access sequencer around key and tile memories.
// Uses sct_pkg, sct_slot, sct_key_mem, sct_tile_mem and the assertion macro header.
//
// channel | handshake          | payload
// --------+--------------------+-------------------
// in      | in_valid, in_ready | in_data  (in_t)
// out     | out_valid,out_ready| out_data (out_t)
//
// Per transaction: an accept state, hashing (plus a reciprocal divide when the slot count
// is not a power of two), a key read then a compare per chain hop, and a completion state.
// A read hit adds a tile read, a write hit one tile write; creating a chunk adds 1-2 key
// writes and one tile write per tile of the chunk (256 at the defaults).
// Reset clears valid flags, the pool counter and the sequencer; memories are not swept.
// A full output register stalls only the completion state until out_ready.
`include "sparse_chunked_tile_store_top_defines.svh"
module sparse_chunked_tile_store_top #(
	parameter int TILE_SHIFT  = sct_pkg::TILE_SHIFT_DEF,
	parameter int HASH_SLOTS  = sct_pkg::HASH_SLOTS_DEF,
	parameter int POOL_CHUNKS = sct_pkg::POOL_CHUNKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sct_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sct_pkg::out_t out_data
);
	localparam int ENTRIES = HASH_SLOTS + POOL_CHUNKS;
	localparam int ENTRY_W = $clog2(ENTRIES);
	localparam int SLOT_W  = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
	localparam int PNF_W   = $clog2(POOL_CHUNKS + 1);
	localparam int OFFS_W  = 2 * TILE_SHIFT;
	localparam int KX_W    = 32 - TILE_SHIFT;
	localparam int KW      = 2 * KX_W + 32 + ENTRY_W;
	localparam int TA_W    = ENTRY_W + OFFS_W;

	sct_pkg::state_t state_q, state_d;
	logic               kind_q;
	logic [31:0]        cx_q, cy_q, cz_q, wv_q;
	logic [OFFS_W-1:0]  offs_q, fill_q;
	logic [ENTRY_W-1:0] e_q, last_q, tgt_q;
	logic [KW-1:0]      lastw_q;
	logic               first_q, slotv_q, link_need_q;
	logic [PNF_W-1:0]   pnf_q;
	sct_pkg::out_t      res_q, out_q;
	logic               ov_q;

	logic               slot_start, slot_done;
	logic [SLOT_W-1:0]  slot;
	sct_pkg::kctl_t     kctl;
	logic [ENTRY_W-1:0] kaddr;
	logic [KW-1:0]      kwdata, krd;
	logic               kvld;
	logic               twe, tre;
	logic [TA_W-1:0]    taddr;
	logic [31:0]        twdata, trd;

	logic [31:0]        cx_in, cy_in;
	logic [KX_W-1:0]    rd_x, rd_y;
	logic [31:0]        rd_z;
	logic [ENTRY_W-1:0] rd_link, link;
	logic               match, chain_end, slot_used, pool_left;
	logic [ENTRY_W-1:0] new_entry;

	assign cx_in = 32'(in_data.tile_x >>> TILE_SHIFT);
	assign cy_in = 32'(in_data.tile_y >>> TILE_SHIFT);

	// Split the key word read back from the key memory
	assign rd_x      = krd[KW-1 -: KX_W];
	assign rd_y      = krd[KW-KX_W-1 -: KX_W];
	assign rd_z      = krd[ENTRY_W +: 32];
	assign rd_link   = krd[ENTRY_W-1:0];
	assign match     = kvld && rd_x == cx_q[KX_W-1:0] && rd_y == cy_q[KX_W-1:0] && rd_z == cz_q;
	assign link      = kvld ? rd_link : '0;
	assign chain_end = link == '0 || {1'b0, link} >= (ENTRY_W + 1)'(ENTRIES);
	assign slot_used = first_q ? kvld : slotv_q;
	assign pool_left = pnf_q < PNF_W'(POOL_CHUNKS);
	assign new_entry = ENTRY_W'(HASH_SLOTS) + ENTRY_W'(pnf_q);

	assign in_ready  = state_q == sct_pkg::S_IDLE;
	assign out_valid = ov_q;
	assign out_data  = out_q;

	sct_slot #(.HASH_SLOTS(HASH_SLOTS), .SLOT_W(SLOT_W)) u_slot (
		.clk(clk), .arst_n(arst_n), .start(slot_start),
		.cx(cx_q), .cy(cy_q), .cz(cz_q), .done(slot_done), .slot(slot)
	);

	sct_key_mem #(.ENTRIES(ENTRIES), .ENTRY_W(ENTRY_W), .KW(KW)) u_key_mem (
		.clk(clk), .arst_n(arst_n), .ctl(kctl), .addr(kaddr),
		.wdata(kwdata), .rdata(krd), .rvalid(kvld)
	);

	sct_tile_mem #(.DEPTH(ENTRIES << OFFS_W), .AW(TA_W)) u_tile_mem (
		.clk(clk), .we(twe), .re(tre), .addr(taddr), .wdata(twdata), .rdata(trd)
	);

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sct_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d    = state_q;
		slot_start = 1'b0;
		kctl       = '0;
		kaddr      = e_q;
		kwdata     = {cx_q[KX_W-1:0], cy_q[KX_W-1:0], cz_q, {ENTRY_W{1'b0}}};
		twe        = 1'b0;
		tre        = 1'b0;
		taddr      = {e_q, offs_q};
		twdata     = wv_q;
		case (state_q)
			sct_pkg::S_IDLE: begin
				if (in_valid) state_d = sct_pkg::S_HASH;
			end
			sct_pkg::S_HASH: begin
				slot_start = 1'b1;
				if (slot_done) state_d = sct_pkg::S_KREAD;
			end
			sct_pkg::S_KREAD: begin
				kctl.re = 1'b1;
				state_d = sct_pkg::S_KCMP;
			end
			sct_pkg::S_KCMP: begin
				if (match) begin
					state_d = (kind_q == sct_pkg::KIND_READ) ? sct_pkg::S_TREAD : sct_pkg::S_STORE;
				end else if (!chain_end) begin
					state_d = sct_pkg::S_KREAD;
				end else if (kind_q == sct_pkg::KIND_READ) begin
					state_d = sct_pkg::S_DONE;
				end else if (!slot_used || pool_left) begin
					state_d = sct_pkg::S_NEWKEY;
				end else begin
					state_d = sct_pkg::S_DONE;
				end
			end
			sct_pkg::S_NEWKEY: begin
				kctl.we        = 1'b1;
				kctl.set_valid = 1'b1;
				kaddr          = tgt_q;
				state_d        = link_need_q ? sct_pkg::S_LINK : sct_pkg::S_FILL;
			end
			sct_pkg::S_LINK: begin
				kctl.we = 1'b1;
				kaddr   = last_q;
				kwdata  = {lastw_q[KW-1:ENTRY_W], tgt_q};
				state_d = sct_pkg::S_FILL;
			end
			sct_pkg::S_FILL: begin
				twe    = 1'b1;
				taddr  = {tgt_q, fill_q};
				twdata = (fill_q == offs_q) ? wv_q : 32'd1;
				if (fill_q == '1) state_d = sct_pkg::S_DONE;
			end
			sct_pkg::S_STORE: begin
				twe     = 1'b1;
				state_d = sct_pkg::S_DONE;
			end
			sct_pkg::S_TREAD: begin
				tre     = 1'b1;
				state_d = sct_pkg::S_TDATA;
			end
			sct_pkg::S_TDATA: begin
				state_d = sct_pkg::S_DONE;
			end
			sct_pkg::S_DONE: begin
				if (!ov_q || out_ready) state_d = sct_pkg::S_IDLE;
			end
			default: state_d = sct_pkg::S_IDLE;
		endcase
	end

	// Control registers: pool counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnf_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (state_q == sct_pkg::S_KCMP && !match && chain_end &&
			    kind_q == sct_pkg::KIND_WRITE && slot_used && pool_left) begin
				pnf_q <= pnf_q + PNF_W'(1);
			end
			if (state_q == sct_pkg::S_DONE && (!ov_q || out_ready)) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers along the walk
	always_ff @(posedge clk) begin
		case (state_q)
			sct_pkg::S_IDLE: begin
				if (in_valid) begin
					kind_q <= in_data.kind;
					cx_q   <= cx_in;
					cy_q   <= cy_in;
					cz_q   <= in_data.tile_z;
					wv_q   <= in_data.write_value;
					offs_q <= {in_data.tile_y[TILE_SHIFT-1:0], in_data.tile_x[TILE_SHIFT-1:0]};
				end
			end
			sct_pkg::S_HASH: begin
				e_q     <= ENTRY_W'(slot);
				first_q <= 1'b1;
			end
			sct_pkg::S_KCMP: begin
				first_q <= 1'b0;
				if (first_q) slotv_q <= kvld;
				fill_q  <= '0;
				if (match) begin
					res_q <= '{read_value: 32'd0, chunk_found: 1'b1, pool_full: 1'b0};
				end else begin
					last_q  <= e_q;
					lastw_q <= krd;
					if (!chain_end) begin
						e_q <= link;
					end else if (kind_q == sct_pkg::KIND_READ) begin
						res_q <= '0;
					end else if (!slot_used) begin
						tgt_q       <= e_q;
						link_need_q <= 1'b0;
						res_q       <= '0;
					end else if (pool_left) begin
						tgt_q       <= new_entry;
						link_need_q <= 1'b1;
						res_q       <= '0;
					end else begin
						res_q <= '{read_value: 32'd0, chunk_found: 1'b0, pool_full: 1'b1};
					end
				end
			end
			sct_pkg::S_FILL: begin
				fill_q <= fill_q + OFFS_W'(1);
			end
			sct_pkg::S_TDATA: begin
				res_q.read_value <= trd;
			end
			sct_pkg::S_DONE: begin
				if (!ov_q || out_ready) out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	`SCT_CHECK(a_pool_bound, pnf_q <= PNF_W'(POOL_CHUNKS), "pool counter ran past the pool size")
	`SCT_CHECK(a_key_port, !(kctl.re && kctl.we), "key memory read and write in one cycle")
	`SCT_IMPLY(a_out_from_done, $rose(ov_q), $past(state_q) == sct_pkg::S_DONE,
		"result raised outside the completion state")
	`SCT_IMPLY(a_fill_new, twe && state_q == sct_pkg::S_FILL, kind_q == sct_pkg::KIND_WRITE,
		"chunk fill on a read transaction")

endmodule

// ===== rtl/sct_slot.sv =====
// Home slot unit: hash 19x+7y+3z and reduce modulo the slot count.
// Uses sct_pkg; reciprocal multiply when the slot count is not a power of two.
module sct_slot #(
	parameter int HASH_SLOTS = sct_pkg::HASH_SLOTS_DEF,
	parameter int SLOT_W     = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       cx,
	input  logic [31:0]       cy,
	input  logic [31:0]       cz,
	output logic              done,
	output logic [SLOT_W-1:0] slot
);
	localparam bit IS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
	localparam logic [31:0] MASK = 32'(HASH_SLOTS - 1);
	localparam int RECIP_SH = 32 + $clog2(HASH_SLOTS);
	localparam logic [63:0] RECIP =
		((64'd1 << RECIP_SH) + 64'(HASH_SLOTS) - 64'd1) / 64'(HASH_SLOTS);
	localparam logic [31:0] RECIP_LO = RECIP[31:0];
	localparam logic RECIP_HI = RECIP[32];
	localparam logic [SLOT_W-1:0] MOD_W = SLOT_W'(HASH_SLOTS);

	sct_pkg::slot_state_t state_q, state_d;
	logic [31:0]       px_s1, py_s1, pz_s1;
	logic [31:0]       hash_q;
	logic [63:0]       prod_q;
	logic [SLOT_W-1:0] quo_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       sum;
	logic [64:0]       prod_full;
	logic [SLOT_W-1:0] quo_mul;

	assign sum       = px_s1 + py_s1 + pz_s1;
	assign prod_full = {1'b0, prod_q} + (RECIP_HI ? {1'b0, hash_q, 32'd0} : 65'd0);
	assign quo_mul   = quo_q * MOD_W;
	assign done      = state_q == sct_pkg::SL_DONE;
	assign slot      = slot_q;

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sct_pkg::SL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sct_pkg::SL_IDLE: if (start) state_d = sct_pkg::SL_SUM;
			sct_pkg::SL_SUM:  state_d = IS_POW2 ? sct_pkg::SL_DONE : sct_pkg::SL_MUL;
			sct_pkg::SL_MUL:  state_d = sct_pkg::SL_QUO;
			sct_pkg::SL_QUO:  state_d = sct_pkg::SL_REM;
			sct_pkg::SL_REM:  state_d = sct_pkg::SL_DONE;
			sct_pkg::SL_DONE: state_d = sct_pkg::SL_IDLE;
			default:          state_d = sct_pkg::SL_IDLE;
		endcase
	end

	// Hold the products, then the sum, then quotient by reciprocal and remainder
	always_ff @(posedge clk) begin
		if (state_q == sct_pkg::SL_IDLE && start) begin
			px_s1 <= cx * 32'd19;
			py_s1 <= cy * 32'd7;
			pz_s1 <= cz * 32'd3;
		end
		if (state_q == sct_pkg::SL_SUM) begin
			hash_q <= sum;
			slot_q <= SLOT_W'(sum & MASK);
		end
		if (state_q == sct_pkg::SL_MUL) begin
			prod_q <= 64'(hash_q) * 64'(RECIP_LO);
		end
		if (state_q == sct_pkg::SL_QUO) begin
			quo_q <= prod_full[RECIP_SH +: SLOT_W];
		end
		if (state_q == sct_pkg::SL_REM) begin
			slot_q <= hash_q[SLOT_W-1:0] - quo_mul;
		end
	end

endmodule

// ===== rtl/sct_key_mem.sv =====
// Key memory: chunk key and chain link per entry, with per-entry valid flops.
// Uses sct_pkg::kctl_t; one write or one read a cycle, read data registered.
module sct_key_mem #(
	parameter int ENTRIES = 128,
	parameter int ENTRY_W = 7,
	parameter int KW      = 95
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sct_pkg::kctl_t      ctl,
	input  logic [ENTRY_W-1:0]  addr,
	input  logic [KW-1:0]       wdata,
	output logic [KW-1:0]       rdata,
	output logic                rvalid
);
	logic [KW-1:0]      mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [KW-1:0]      rdata_q;
	logic               rvalid_q;

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

	// Set the valid bit of a newly created entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (ctl.we && ctl.set_valid) valid_q[addr] <= 1'b1;
			if (ctl.re) rvalid_q <= valid_q[addr];
		end
	end

	// Write and read the array
	always_ff @(posedge clk) begin
		if (ctl.we) mem[addr] <= wdata;
		if (ctl.re) rdata_q <= mem[addr];
	end

endmodule

// ===== rtl/sct_tile_mem.sv =====
// Tile word memory: one 32-bit word per tile of every entry.
// No dependencies; one access a cycle, read data registered.
module sct_tile_mem #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rdata <= mem[addr];
	end

endmodule

// ===== tb/sparse_chunked_tile_store_top_tb.sv =====
// Self-checking testbench for the sparse chunked tile store (chained-hash tile map).
// Depends on sct_pkg and sparse_chunked_tile_store_top; predicts every result in-line.
module sparse_chunked_tile_store_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHIFT   = sct_pkg::TILE_SHIFT_DEF;
	localparam int SLOTS   = sct_pkg::HASH_SLOTS_DEF;
	localparam int POOL    = sct_pkg::POOL_CHUNKS_DEF;
	localparam int ENTRIES = SLOTS + POOL;
	localparam int TILES   = 1 << (2 * SHIFT);
	localparam int DIM     = 1 << SHIFT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sct_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sct_pkg::out_t out_data;

	sparse_chunked_tile_store_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the tile map
	bit          map_valid [ENTRIES];
	logic [31:0] map_cx [ENTRIES];
	logic [31:0] map_cy [ENTRIES];
	logic [31:0] map_cz [ENTRIES];
	int unsigned map_link [ENTRIES];
	int unsigned pool_used;
	logic [31:0] map_tiles [ENTRIES * TILES];

	sct_pkg::in_t  pending_accesses [$];
	sct_pkg::out_t expected_results [$];
	int   mismatches = 0;
	bit   calm = 1'b0;
	int   in_gap = 0;
	int   out_gap = 0;

	// Compute the result of one access and update the shadow map
	function automatic sct_pkg::out_t access_tile_map(sct_pkg::in_t a);
		logic [31:0] cx, cy, cz, hash;
		int unsigned offs, slot, e, last, tgt;
		bit found;
		sct_pkg::out_t r;
		cx = 32'(a.tile_x >>> SHIFT);
		cy = 32'(a.tile_y >>> SHIFT);
		cz = a.tile_z;
		offs = (a.tile_y[SHIFT-1:0] * DIM) + a.tile_x[SHIFT-1:0];
		hash = 32'd19 * cx + 32'd7 * cy + 32'd3 * cz;
		slot = hash % SLOTS;
		e = slot;
		last = slot;
		found = 1'b0;
		tgt = ENTRIES;
		r = '0;
		for (int n = 0; n < ENTRIES; n++) begin
			if (map_valid[e] && map_cx[e] == cx && map_cy[e] == cy && map_cz[e] == cz) begin
				found = 1'b1;
				break;
			end
			last = e;
			if (map_link[e] == 0 || map_link[e] >= ENTRIES) break;
			e = map_link[e];
		end
		if (a.kind == sct_pkg::KIND_READ) begin
			if (found) r.read_value = map_tiles[e * TILES + offs];
		end else if (found) begin
			tgt = e;
		end else if (!map_valid[slot]) begin
			tgt = slot;
		end else if (pool_used < POOL) begin
			tgt = SLOTS + pool_used;
			pool_used++;
			map_link[last] = tgt;
		end else begin
			r.pool_full = 1'b1;
		end
		// Create a new chunk filled with ones if none was found, then store
		if (tgt < ENTRIES) begin
			if (!found) begin
				map_valid[tgt] = 1'b1;
				map_cx[tgt] = cx;
				map_cy[tgt] = cy;
				map_cz[tgt] = cz;
				map_link[tgt] = 0;
				for (int i = 0; i < TILES; i++) map_tiles[tgt * TILES + i] = 32'd1;
			end
			map_tiles[tgt * TILES + offs] = a.write_value;
		end
		r.chunk_found = found;
		return r;
	endfunction

	function automatic sct_pkg::in_t make_access(bit kind, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] v);
		sct_pkg::in_t a;
		a.kind = kind;
		a.tile_x = x;
		a.tile_y = y;
		a.tile_z = z;
		a.write_value = v;
		return a;
	endfunction

	// Coordinates clustered on a few chunks so that hits and chains are common
	function automatic logic [31:0] near_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7fff_fff0 + $urandom_range(0, 15);
			2: return 32'h8000_0000 + $urandom_range(0, 15);
			default: return 32'($signed($urandom_range(0, 95)) - 48);
		endcase
	endfunction

	// Driver: present queued transactions, idling in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(access_tile_map(in_data));
				void'(pending_accesses.pop_front());
			end
			if (in_valid && !in_ready) begin
				// hold until accepted
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				in_gap <= $urandom_range(1, 10);
				in_valid <= 1'b0;
			end else if (pending_accesses.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_accesses[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					sct_pkg::out_t exp_r;
					exp_r = expected_results.pop_front();
					if (exp_r.read_value !== out_data.read_value ||
							exp_r.chunk_found !== out_data.chunk_found ||
							exp_r.pool_full !== out_data.pool_full) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", exp_r, out_data);
					end
				end
			end
			// Stall the result side in random bursts
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(1, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] x, y, z;
		foreach (map_valid[i]) begin
			map_valid[i] = 1'b0;
			map_link[i] = 0;
		end
		pool_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: absent read, create, hit, extremes, collisions
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 0, 0, 0, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 0, 0, 0, 32'hffff_ffff));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 0, 0, 0, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 5, 9, 0, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'ha5a5_5a5a));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'h5a5a_a5a5));
		// Same home slot (z differs by 64): chains into the pool
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 0, 0, 64, 32'd7));
		pending_accesses.push_back(make_access(sct_pkg::KIND_WRITE, 0, 0, 128, 32'd8));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 0, 0, 128, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 0, 0, 192, 0));
		pending_accesses.push_back(make_access(sct_pkg::KIND_READ, 15, 15, 64, 0));

		// Random: mostly clustered accesses; pool eventually exhausts
		for (int i = 0; i < 1536; i++) begin
			x = near_coord();
			y = near_coord();
			z = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
			pending_accesses.push_back(make_access(1'($urandom_range(0, 1)), x, y, z,
				$urandom));
			if (i == 1200) calm = 1'b1;
			while (pending_accesses.size() > 8) @(posedge clk);
		end
		while (pending_accesses.size() > 0 || in_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far above the slowest legal run
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
